### hw/rtl/lmx_pkg.sv
// Shared types and codes for the Lamport mutual exclusion node.
// No dependencies; lmx_front, lmx_back and lamport_mutex_node refer to this package by scoped names.
package lmx_pkg;

    // Input action codes
    localparam logic [1:0] ACT_LOCAL_REQ = 2'd0;
    localparam logic [1:0] ACT_LOCAL_REL = 2'd1;
    localparam logic [1:0] ACT_RECV      = 2'd2;

    // Received message kinds
    localparam logic [1:0] MSG_REQ  = 2'd0;
    localparam logic [1:0] MSG_REP  = 2'd1;
    localparam logic [1:0] MSG_REL  = 2'd2;
    localparam logic [1:0] MSG_DONE = 2'd3;

    // Configuration register indexes
    localparam logic CFG_PROCESS_COUNT = 1'b0;
    localparam logic CFG_OWN_ID        = 1'b1;

    // Reset values of the configuration registers
    localparam logic [4:0] PROCESS_COUNT_RST = 5'd4;
    localparam logic [3:0] OWN_ID_RST        = 4'd1;

    // Outgoing message kinds
    typedef enum logic [1:0] {
        SEND_NONE  = 2'd0,
        SEND_REPLY = 2'd1,
        SEND_REQ   = 2'd2,
        SEND_REL   = 2'd3
    } t_send;

    // Classified operations handed from the front to the back
    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_LREQ       = 3'd1,
        OP_LREL       = 3'd2,
        OP_LREL_NOOWN = 3'd3,
        OP_RX_REQ     = 3'd4,
        OP_RX_REP     = 3'd5,
        OP_RX_REL     = 3'd6,
        OP_RX_DONE    = 3'd7
    } t_op;

    // One classified request (the stamp travels beside it)
    typedef struct packed {
        t_op        op;
        logic [3:0] sender;
    } t_cmd;

    // Configuration view seen by front and back
    typedef struct packed {
        logic       own_ok;
        logic [3:0] own_id;
    } t_cfg;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        B_IDLE  = 3'd0,
        B_CHECK = 3'd1,
        B_OWN   = 3'd2,
        B_SCAN  = 3'd3,
        B_PUSH  = 3'd4
    } t_bstate;

endpackage

### hw/rtl/lmx_fifo.sv
// Two-entry queue for a flat payload word.
// Depends on nothing; used for the command queue and the result queue.
module lmx_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Hold payload words
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hw/rtl/lmx_front.sv
// Front end: classifies an incoming request into a back-end operation.
// Depends on lmx_pkg; checks local ids and senders against the configuration.
module lmx_front #(
    parameter int EW = 5
) (
    input  logic [1:0]    i_action,
    input  logic [1:0]    i_msg_kind,
    input  logic [3:0]    i_sender,
    input  logic [EW-1:0] i_eff_count,
    input  lmx_pkg::t_cfg i_cfg,
    output lmx_pkg::t_cmd o_cmd
);

    logic sender_ok;

    // Drop messages from ourselves or from ids beyond the process count
    assign sender_ok = (i_sender != i_cfg.own_id) && (EW'(i_sender) < i_eff_count);

    // Decode action and message kind
    always_comb begin
        o_cmd.sender = i_sender;
        o_cmd.op     = lmx_pkg::OP_NONE;
        unique case (i_action)
            lmx_pkg::ACT_LOCAL_REQ: begin
                if (i_cfg.own_ok) begin
                    o_cmd.op = lmx_pkg::OP_LREQ;
                end
            end
            lmx_pkg::ACT_LOCAL_REL: begin
                o_cmd.op = i_cfg.own_ok ? lmx_pkg::OP_LREL : lmx_pkg::OP_LREL_NOOWN;
            end
            lmx_pkg::ACT_RECV: begin
                if (sender_ok) begin
                    unique case (i_msg_kind)
                        lmx_pkg::MSG_REQ:  o_cmd.op = lmx_pkg::OP_RX_REQ;
                        lmx_pkg::MSG_REP:  o_cmd.op = lmx_pkg::OP_RX_REP;
                        lmx_pkg::MSG_REL:  o_cmd.op = lmx_pkg::OP_RX_REL;
                        lmx_pkg::MSG_DONE: o_cmd.op = lmx_pkg::OP_RX_DONE;
                        default:           o_cmd.op = lmx_pkg::OP_NONE;
                    endcase
                end
            end
            default: o_cmd.op = lmx_pkg::OP_NONE;
        endcase
    end

endmodule

### hw/rtl/lmx_back.sv
// Back end: applies one operation to the node state, then scans the request
// queue for the grant. Depends on lmx_pkg; holds the queue stamp memory.
module lmx_back #(
    parameter int MAX_PROCESSES = 16,
    parameter int TIME_BITS     = 15,
    parameter int EW            = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lmx_pkg::t_cmd        i_cmd,
    input  logic [TIME_BITS-1:0] i_stamp,
    input  logic                 i_cmd_empty,
    output logic                 o_cmd_pop,
    input  logic [EW-1:0]        i_eff_count,
    input  lmx_pkg::t_cfg        i_cfg,
    input  logic                 i_res_full,
    output logic                 o_res_push,
    output logic [1:0]           o_send_kind,
    output logic [3:0]           o_send_dest,
    output logic [TIME_BITS-1:0] o_send_time,
    output logic                 o_granted,
    output logic [TIME_BITS-1:0] o_clock_now,
    output logic [3:0]           o_done_count
);

    localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    lmx_pkg::t_bstate     r_state, n_state;
    logic [TIME_BITS-1:0] r_clock, n_clock;
    logic [TIME_BITS-1:0] r_own_time, n_own_time;
    logic [3:0]           r_reply, n_reply;
    logic                 r_pending, n_pending;
    logic [3:0]           r_done, n_done;
    logic                 r_valid [MAX_PROCESSES];
    logic                 n_valid [MAX_PROCESSES];
    logic [IW-1:0]        r_idx, n_idx;
    logic [TIME_BITS-1:0] r_mine, n_mine;
    logic                 r_grant, n_grant;
    lmx_pkg::t_send       r_kind, n_kind;
    logic [3:0]           r_dest, n_dest;
    logic [TIME_BITS-1:0] r_time, n_time;

    logic [TIME_BITS-1:0] r_mem [MAX_PROCESSES];
    logic [TIME_BITS-1:0] r_rd_data;
    logic [IW-1:0]        rd_addr;
    logic                 mem_we;
    logic [IW-1:0]        mem_wa;
    logic [TIME_BITS-1:0] mem_wd;

    logic [IW+3:0]        sender_ext;
    logic [IW+3:0]        own_ext;
    logic [IW-1:0]        sender_idx;
    logic [IW-1:0]        own_idx;
    logic [TIME_BITS-1:0] rx_max;
    logic [TIME_BITS-1:0] rx_tick;
    logic [TIME_BITS-1:0] tx_tick;
    logic [TIME_BITS-1:0] rxtx_tick;
    logic                 skip;
    logic                 older;

    // Map 4-bit ids onto queue indexes
    assign sender_ext = {{IW{1'b0}}, i_cmd.sender};
    assign own_ext    = {{IW{1'b0}}, i_cfg.own_id};
    assign sender_idx = sender_ext[IW-1:0];
    assign own_idx    = own_ext[IW-1:0];

    // Saturating clock updates: receive, send, and receive followed by send
    assign rx_max    = (i_stamp > r_clock) ? i_stamp : r_clock;
    assign rx_tick   = (rx_max == TIME_MAX) ? rx_max : rx_max + TIME_BITS'(1);
    assign tx_tick   = (r_clock == TIME_MAX) ? r_clock : r_clock + TIME_BITS'(1);
    assign rxtx_tick = (rx_tick == TIME_MAX) ? rx_tick : rx_tick + TIME_BITS'(1);

    // Scan compare: a valid other entry that is older, or equal with lower id, blocks
    assign skip  = (r_idx == own_idx) || !r_valid[r_idx];
    assign older = (r_rd_data < r_mine) || ((r_rd_data == r_mine) && (r_idx < own_idx));

    // Next state and datapath
    always_comb begin
        n_state    = r_state;
        n_clock    = r_clock;
        n_own_time = r_own_time;
        n_reply    = r_reply;
        n_pending  = r_pending;
        n_done     = r_done;
        n_valid    = r_valid;
        n_idx      = r_idx;
        n_mine     = r_mine;
        n_grant    = r_grant;
        n_kind     = r_kind;
        n_dest     = r_dest;
        n_time     = r_time;
        mem_we     = 1'b0;
        mem_wa     = own_idx;
        mem_wd     = tx_tick;
        rd_addr    = own_idx;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            lmx_pkg::B_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_kind    = lmx_pkg::SEND_NONE;
                    n_dest    = 4'd0;
                    n_time    = '0;
                    n_state   = lmx_pkg::B_CHECK;
                    case (i_cmd.op) inside
                        lmx_pkg::OP_LREQ: begin
                            if (!r_pending) begin
                                n_clock          = tx_tick;
                                mem_we           = 1'b1;
                                n_valid[own_idx] = 1'b1;
                                n_own_time       = tx_tick;
                                n_reply          = 4'd0;
                                n_pending        = 1'b1;
                                n_kind           = lmx_pkg::SEND_REQ;
                                n_time           = tx_tick;
                            end
                        end
                        lmx_pkg::OP_LREL, lmx_pkg::OP_LREL_NOOWN: begin
                            if (i_cmd.op == lmx_pkg::OP_LREL) begin
                                n_valid[own_idx] = 1'b0;
                            end
                            n_pending = 1'b0;
                            n_clock   = tx_tick;
                            n_kind    = lmx_pkg::SEND_REL;
                            n_time    = tx_tick;
                        end
                        lmx_pkg::OP_RX_REQ: begin
                            n_clock             = rxtx_tick;
                            mem_we              = 1'b1;
                            mem_wa              = sender_idx;
                            mem_wd              = i_stamp;
                            n_valid[sender_idx] = 1'b1;
                            n_kind              = lmx_pkg::SEND_REPLY;
                            n_dest              = i_cmd.sender;
                            n_time              = rxtx_tick;
                        end
                        lmx_pkg::OP_RX_REP: begin
                            n_clock = rx_tick;
                            if (r_pending && (i_stamp > r_own_time) && (r_reply != 4'd15)) begin
                                n_reply = r_reply + 4'd1;
                            end
                        end
                        lmx_pkg::OP_RX_REL: begin
                            n_clock             = rx_tick;
                            n_valid[sender_idx] = 1'b0;
                        end
                        lmx_pkg::OP_RX_DONE: begin
                            n_clock = rx_tick;
                            if (r_done != 4'd15) begin
                                n_done = r_done + 4'd1;
                            end
                        end
                        default: begin
                            n_clock = r_clock;
                        end
                    endcase
                end
            end
            lmx_pkg::B_CHECK: begin
                if (!r_pending || !i_cfg.own_ok || !r_valid[own_idx]
                        || (EW'(r_reply) < i_eff_count - EW'(2))) begin
                    n_grant = 1'b0;
                    n_state = lmx_pkg::B_PUSH;
                end else begin
                    rd_addr = own_idx;
                    n_state = lmx_pkg::B_OWN;
                end
            end
            lmx_pkg::B_OWN: begin
                n_mine  = r_rd_data;
                rd_addr = '0;
                n_idx   = '0;
                n_state = lmx_pkg::B_SCAN;
            end
            lmx_pkg::B_SCAN: begin
                if (!skip && older) begin
                    n_grant = 1'b0;
                    n_state = lmx_pkg::B_PUSH;
                end else if (EW'(r_idx) == i_eff_count - EW'(1)) begin
                    n_grant = 1'b1;
                    n_state = lmx_pkg::B_PUSH;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    rd_addr = r_idx + IW'(1);
                end
            end
            lmx_pkg::B_PUSH: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = lmx_pkg::B_IDLE;
                end
            end
            default: n_state = lmx_pkg::B_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmx_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Node state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock    <= '0;
            r_own_time <= '0;
            r_reply    <= 4'd0;
            r_pending  <= 1'b0;
            r_done     <= 4'd0;
            for (int i = 0; i < MAX_PROCESSES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_clock    <= n_clock;
            r_own_time <= n_own_time;
            r_reply    <= n_reply;
            r_pending  <= n_pending;
            r_done     <= n_done;
            r_valid    <= n_valid;
        end
    end

    // Scan and result payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_mine  <= n_mine;
        r_grant <= n_grant;
        r_kind  <= n_kind;
        r_dest  <= n_dest;
        r_time  <= n_time;
    end

    // Queue stamp memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_send_kind  = r_kind;
    assign o_send_dest  = r_dest;
    assign o_send_time  = r_time;
    assign o_granted    = r_grant;
    assign o_clock_now  = r_clock;
    assign o_done_count = r_done;

`ifndef NO_ASSERTIONS
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lmx_pkg::B_SCAN) |-> (EW'(r_idx) < i_eff_count))
        else $error("scan index beyond process count");

    a_grant_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lmx_pkg::B_PUSH && r_grant) |-> (r_pending && i_cfg.own_ok && r_valid[own_idx]))
        else $error("grant without a pending own request");

    a_clock_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lmx_pkg::B_IDLE && !i_cmd_empty) |=> (r_clock >= $past(r_clock)))
        else $error("logical clock went backward");

    a_push_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |=> (r_state == lmx_pkg::B_IDLE))
        else $error("sequencer did not return after pushing a result");
`endif

endmodule

### hw/rtl/lamport_mutex_node.sv
// Lamport mutual exclusion node. A result follows each accepted request after the back end
// runs its states; the grant scan walks the queue entries up to the process count, one entry
// per cycle through the stamp memory read port, and the back end takes a new request only
// after it has pushed the result of the last one. Both sides buffer two requests.
// Reset (synchronous, active low) empties both queues and all request queue entries,
// zeroes the clock and counters, and sets process_count to 4 and own_id to 1.
module lamport_mutex_node #(
    parameter int MAX_PROCESSES = 16,
    parameter int TIME_BITS     = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           i_action,
    input  logic [1:0]           i_msg_kind,
    input  logic [3:0]           i_sender,
    input  logic [TIME_BITS-1:0] i_msg_time,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           o_send_kind,
    output logic [3:0]           o_send_dest,
    output logic [TIME_BITS-1:0] o_send_time,
    output logic                 o_granted,
    output logic [TIME_BITS-1:0] o_clock_now,
    output logic [3:0]           o_done_count,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [4:0]           i_cfg_data
);

    localparam int CW    = $clog2(MAX_PROCESSES + 1);
    localparam int EW    = (CW > 5) ? CW : 5;
    localparam int CMD_W = $bits(lmx_pkg::t_cmd) + TIME_BITS;
    localparam int RES_W = 2 + 4 + TIME_BITS + 1 + TIME_BITS + 4;

    logic [4:0]           r_process_count;
    logic [3:0]           r_own_id;
    logic [EW-1:0]        pc_ext;
    logic [EW-1:0]        eff_count;
    lmx_pkg::t_cfg        cfg;
    lmx_pkg::t_cmd        front_cmd;
    lmx_pkg::t_cmd        back_cmd;
    logic [CMD_W-1:0]     cmd_head;
    logic [TIME_BITS-1:0] back_stamp;
    logic                 cmd_empty;
    logic                 cmd_pop;
    logic                 res_full;
    logic                 res_push;
    logic [1:0]           b_kind;
    logic [3:0]           b_dest;
    logic [TIME_BITS-1:0] b_time;
    logic                 b_grant;
    logic [TIME_BITS-1:0] b_clock;
    logic [3:0]           b_done;
    logic [RES_W-1:0]     res_head;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_process_count <= lmx_pkg::PROCESS_COUNT_RST;
            r_own_id        <= lmx_pkg::OWN_ID_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lmx_pkg::CFG_PROCESS_COUNT: r_process_count <= i_cfg_data;
                lmx_pkg::CFG_OWN_ID:        r_own_id        <= i_cfg_data[3:0];
                default:                    r_own_id        <= r_own_id;
            endcase
        end
    end

    // Clamp the process count and qualify our own id
    assign pc_ext = EW'(r_process_count);
    always_comb begin
        if (pc_ext < EW'(3)) begin
            eff_count = EW'(3);
        end else if (pc_ext > EW'(MAX_PROCESSES)) begin
            eff_count = EW'(MAX_PROCESSES);
        end else begin
            eff_count = pc_ext;
        end
    end
    assign cfg.own_id = r_own_id;
    assign cfg.own_ok = (r_own_id != 4'd0) && (EW'(r_own_id) < eff_count);

    lmx_front #(
        .EW(EW)
    ) u_front (
        .i_action    (i_action),
        .i_msg_kind  (i_msg_kind),
        .i_sender    (i_sender),
        .i_eff_count (eff_count),
        .i_cfg       (cfg),
        .o_cmd       (front_cmd)
    );

    lmx_fifo #(
        .W(CMD_W)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_cmd, i_msg_time}),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_head)
    );

    assign back_cmd   = cmd_head[CMD_W-1:TIME_BITS];
    assign back_stamp = cmd_head[TIME_BITS-1:0];

    lmx_back #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .TIME_BITS     (TIME_BITS),
        .EW            (EW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (back_cmd),
        .i_stamp      (back_stamp),
        .i_cmd_empty  (cmd_empty),
        .o_cmd_pop    (cmd_pop),
        .i_eff_count  (eff_count),
        .i_cfg        (cfg),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_send_kind  (b_kind),
        .o_send_dest  (b_dest),
        .o_send_time  (b_time),
        .o_granted    (b_grant),
        .o_clock_now  (b_clock),
        .o_done_count (b_done)
    );

    lmx_fifo #(
        .W(RES_W)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  ({b_kind, b_dest, b_time, b_grant, b_clock, b_done}),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_head)
    );

    // Unpack the oldest result
    assign {o_send_kind, o_send_dest, o_send_time, o_granted, o_clock_now, o_done_count} =
        res_head;

endmodule
